@@ sv/idwa_pkg.sv @@
// ----------------------------------------------------------------------------
// idwa_pkg
// Shared types and constants for the IMU deadband window average unit.
// ----------------------------------------------------------------------------
package idwa_pkg;

  // Width of every sample and average.
  localparam int SAMPLE_W = 16;

  // Width of the deadband register.
  localparam int DEADBAND_W = 16;

  // Number of filtered channels: three accelerometer and three gyro axes.
  localparam int NUM_CHANNELS = 6;

  // Default window length.
  localparam int WINDOW_LENGTH_DEF = 8;

  // Deadband value after reset.
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd500;

  // Per-channel control from the pipeline controller.
  typedef struct packed {
    logic push;  // A sample transfer updates the window and the running sum.
    logic load;  // The average register takes the new average.
  } chan_ctrl_t;

endpackage

@@ sv/idwa_channel.sv @@
// ----------------------------------------------------------------------------
// idwa_channel
// One filter channel: a sliding window kept as a shift line, a running sum,
// and a divide-by-length through a reciprocal multiply into an output register.
// ----------------------------------------------------------------------------
module idwa_channel #(
  parameter int WINDOW_LENGTH = idwa_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  idwa_pkg::chan_ctrl_t                  ctrl,
  input  logic signed [idwa_pkg::SAMPLE_W-1:0]  sample_i,
  output logic signed [idwa_pkg::SAMPLE_W-1:0]  avg_o
);

  localparam int SW      = idwa_pkg::SAMPLE_W;
  localparam int LEN_LOG = $clog2(WINDOW_LENGTH);
  // The sum of the window fits in SUM_W signed bits, its magnitude in SUM_W bits.
  localparam int SUM_W   = SW + LEN_LOG;
  localparam int SHIFT   = SUM_W + LEN_LOG;
  localparam longint RECIP =
    ((longint'(1) << SHIFT) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QUOT_W  = SW + 1;

  logic signed [SW-1:0]    win_r [WINDOW_LENGTH];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0]        sum_mag;
  logic [RECIP_W-1:0]      recip;
  logic [PROD_W-1:0]       prod;
  logic [QUOT_W-1:0]       quot;
  logic signed [SW-1:0]    avg_nxt;
  logic signed [SW-1:0]    avg_r;

  // Running sum: add the new sample and drop the oldest one.
  always_comb begin
    sum_nxt = sum_r + SUM_W'(sample_i) - SUM_W'(win_r[0]);
  end

  // Window shift line and running sum; the oldest sample sits at index 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (ctrl.push) begin
      for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW_LENGTH-1] <= sample_i;
      sum_r                  <= sum_nxt;
    end
  end

  // Divide the magnitude by the length with a rounded-up reciprocal, which is
  // exact for every magnitude below 2**SUM_W, then restore the sign so the
  // quotient truncates toward zero.
  always_comb begin
    sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    recip   = RECIP_W'(RECIP);
    prod    = {{RECIP_W{1'b0}}, sum_mag} * {{SUM_W{1'b0}}, recip};
    quot    = prod[SHIFT +: QUOT_W];
    avg_nxt = sum_r[SUM_W-1] ? SW'(-quot) : quot[SW-1:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      avg_r <= avg_nxt;
    end
  end

  assign avg_o = avg_r;

endmodule

@@ sv/imu_deadband_window_average_unit.sv @@
// ----------------------------------------------------------------------------
// imu_deadband_window_average_unit
// Six-channel moving average with a gyro deadband: still gyro samples are
// zeroed, then every axis is averaged over its newest WINDOW_LENGTH samples.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// in_       in_valid / in_ready     in_accel_x..z, in_gyro_x..z (16b signed)
// out_      out_valid / out_ready   out_avg_accel_x..z, out_avg_gyro_x..z
// cfg_      cfg_valid / cfg_ready   cfg_data: gyro deadband (16b unsigned)
//
// One sample is taken every cycle unless out_ready stalls; the transfer updates
// the running sums, and the averages reach out_ when the sum stage loads the
// output register. The rate is set by the running sum, updated once per sample.
// Reset (rst_n low, synchronous) clears the windows, the sums and the valid
// flags and sets the deadband to 500. With the result held by out_ready low,
// one more sample is still taken into the sum stage before in_ready drops.
// ----------------------------------------------------------------------------
module imu_deadband_window_average_unit #(
  parameter int WINDOW_LENGTH = idwa_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [idwa_pkg::SAMPLE_W-1:0]   in_accel_x,
  input  logic signed [idwa_pkg::SAMPLE_W-1:0]   in_accel_y,
  input  logic signed [idwa_pkg::SAMPLE_W-1:0]   in_accel_z,
  input  logic signed [idwa_pkg::SAMPLE_W-1:0]   in_gyro_x,
  input  logic signed [idwa_pkg::SAMPLE_W-1:0]   in_gyro_y,
  input  logic signed [idwa_pkg::SAMPLE_W-1:0]   in_gyro_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [idwa_pkg::SAMPLE_W-1:0]   out_avg_accel_x,
  output logic signed [idwa_pkg::SAMPLE_W-1:0]   out_avg_accel_y,
  output logic signed [idwa_pkg::SAMPLE_W-1:0]   out_avg_accel_z,
  output logic signed [idwa_pkg::SAMPLE_W-1:0]   out_avg_gyro_x,
  output logic signed [idwa_pkg::SAMPLE_W-1:0]   out_avg_gyro_y,
  output logic signed [idwa_pkg::SAMPLE_W-1:0]   out_avg_gyro_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [idwa_pkg::DEADBAND_W-1:0]        cfg_data
);

  localparam int SW = idwa_pkg::SAMPLE_W;
  localparam int NC = idwa_pkg::NUM_CHANNELS;

  logic [idwa_pkg::DEADBAND_W-1:0] deadband_r;
  logic                            sum_vld_r;
  logic                            out_vld_r;
  logic                            sum_vld_nxt;
  logic                            out_vld_nxt;
  logic                            push;
  logic                            load;
  logic                            gyro_still;
  logic signed [SW-1:0]            sample [NC];
  logic signed [SW-1:0]            avg    [NC];
  idwa_pkg::chan_ctrl_t            ctrl;

  // Magnitude of a sample; the most negative value maps to 32768 without wrap.
  function automatic logic [SW:0] mag(input logic signed [SW-1:0] x);
    logic [SW:0] ext;
    ext = {x[SW-1], x};
    return x[SW-1] ? -ext : ext;
  endfunction

  // Deadband register; writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= idwa_pkg::DEADBAND_RESET;
    end else if (cfg_valid) begin
      deadband_r <= cfg_data;
    end
  end

  // The gyro is still when every axis magnitude is strictly below the deadband.
  always_comb begin
    gyro_still = (mag(in_gyro_x) < {1'b0, deadband_r}) &&
                 (mag(in_gyro_y) < {1'b0, deadband_r}) &&
                 (mag(in_gyro_z) < {1'b0, deadband_r});
    sample[0] = in_accel_x;
    sample[1] = in_accel_y;
    sample[2] = in_accel_z;
    sample[3] = gyro_still ? '0 : in_gyro_x;
    sample[4] = gyro_still ? '0 : in_gyro_y;
    sample[5] = gyro_still ? '0 : in_gyro_z;
  end

  // Two-stage pipeline control: sum stage, then the output register.
  always_comb begin
    load        = sum_vld_r && (!out_vld_r || out_ready);
    in_ready    = !sum_vld_r || load;
    push        = in_valid && in_ready;
    sum_vld_nxt = push || (sum_vld_r && !load);
    out_vld_nxt = load || (out_vld_r && !out_ready);
    ctrl.push   = push;
    ctrl.load   = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= sum_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // One filter channel per axis.
  for (genvar c = 0; c < NC; c++) begin : g_chan
    idwa_channel #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sample_i (sample[c]),
      .avg_o    (avg[c])
    );
  end

  assign out_valid       = out_vld_r;
  assign out_avg_accel_x = avg[0];
  assign out_avg_accel_y = avg[1];
  assign out_avg_accel_z = avg[2];
  assign out_avg_gyro_x  = avg[3];
  assign out_avg_gyro_y  = avg[4];
  assign out_avg_gyro_z  = avg[5];

`ifndef NO_ASSERTIONS
  // A full pipeline with a stalled result takes no new sample.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_vld_r && out_vld_r && !out_ready) |-> !in_ready)
    else $error("sample taken while the pipeline is full and stalled");

  // Every input transfer occupies the sum stage in the next cycle.
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> sum_vld_r)
    else $error("input transfer lost before the sum stage");

  // A sum-stage item moves into the output register when it has room.
  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_vld_r && (!out_vld_r || out_ready)) |=> out_vld_r)
    else $error("sum stage item not moved to the output register");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !sum_vld_r))
    else $error("valid flag set after reset");
`endif

endmodule

@@ tb/imu_deadband_window_average_unit_test.sv @@
// ----------------------------------------------------------------------------
// imu_deadband_window_average_unit_test
// Self-checking bench for the IMU deadband window average unit. Samples are
// sent over the in_ channel with random gaps and the averages are taken on
// the out_ channel under random back-pressure. An in-bench model of the gyro
// deadband and the six sliding windows predicts every average, and each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module imu_deadband_window_average_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_LEN = idwa_pkg::WINDOW_LENGTH_DEF;
  localparam int NUM_CH = idwa_pkg::NUM_CHANNELS;
  localparam int SW = idwa_pkg::SAMPLE_W;
  localparam int DBW = idwa_pkg::DEADBAND_W;
  // Channel order: three accelerometer axes, then three gyro axes.
  localparam int FIRST_GYRO = 3;
  localparam int RANDOM_ITEMS = 1350;
  localparam int NUM_PHASES = 7;

  typedef logic signed [SW-1:0] axis_t;
  typedef axis_t [NUM_CH-1:0] imu_vec_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  axis_t in_accel_x;
  axis_t in_accel_y;
  axis_t in_accel_z;
  axis_t in_gyro_x;
  axis_t in_gyro_y;
  axis_t in_gyro_z;
  logic out_valid;
  logic out_ready;
  axis_t out_avg_accel_x;
  axis_t out_avg_accel_y;
  axis_t out_avg_accel_z;
  axis_t out_avg_gyro_x;
  axis_t out_avg_gyro_y;
  axis_t out_avg_gyro_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [DBW-1:0] cfg_data;

  // Model state: one window per channel and the deadband register.
  axis_t window_mem [NUM_CH][WIN_LEN];
  logic [DBW-1:0] deadband_model;
  imu_vec_t pending_averages [$];
  int fail_count;
  bit src_idle_en;
  bit sink_stall_en;
  string axis_name [NUM_CH] = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                                "avg_gyro_x", "avg_gyro_y", "avg_gyro_z"};

  imu_deadband_window_average_unit #(
    .WINDOW_LENGTH(WIN_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_accel_x(in_accel_x),
    .in_accel_y(in_accel_y),
    .in_accel_z(in_accel_z),
    .in_gyro_x(in_gyro_x),
    .in_gyro_y(in_gyro_y),
    .in_gyro_z(in_gyro_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_avg_accel_x(out_avg_accel_x),
    .out_avg_accel_y(out_avg_accel_y),
    .out_avg_accel_z(out_avg_accel_z),
    .out_avg_gyro_x(out_avg_gyro_x),
    .out_avg_gyro_y(out_avg_gyro_y),
    .out_avg_gyro_z(out_avg_gyro_z),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Values as they stood just before each rising edge.
  clocking mon_cb @(posedge clk);
    input rst_n, in_ready, out_valid, out_ready, cfg_ready;
    input out_avg_accel_x, out_avg_accel_y, out_avg_accel_z;
    input out_avg_gyro_x, out_avg_gyro_y, out_avg_gyro_z;
  endclocking

  // Hard stop in case the pipeline hangs.
  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Magnitude on 17 bits, so the most negative value gives 32768.
  function automatic logic [SW:0] magnitude(input axis_t v);
    logic signed [SW:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // Apply the deadband, push the sample into the windows and return the
  // six truncated averages.
  function automatic imu_vec_t filter_sample(input imu_vec_t s);
    imu_vec_t avg;
    axis_t v;
    bit still;
    int sum;
    int c;
    int i;
    still = magnitude(s[FIRST_GYRO]) < {1'b0, deadband_model} &&
            magnitude(s[FIRST_GYRO+1]) < {1'b0, deadband_model} &&
            magnitude(s[FIRST_GYRO+2]) < {1'b0, deadband_model};
    for (c = 0; c < NUM_CH; c++) begin
      v = (still && c >= FIRST_GYRO) ? axis_t'(0) : s[c];
      for (i = 1; i < WIN_LEN; i++) window_mem[c][i-1] = window_mem[c][i];
      window_mem[c][WIN_LEN-1] = v;
      sum = 0;
      for (i = 0; i < WIN_LEN; i++) sum += window_mem[c][i];
      avg[c] = axis_t'(sum / WIN_LEN);
    end
    return avg;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic imu_vec_t make_sample(input int ax, input int ay, input int az,
                                           input int gx, input int gy, input int gz);
    imu_vec_t s;
    s[0] = axis_t'(ax);
    s[1] = axis_t'(ay);
    s[2] = axis_t'(az);
    s[3] = axis_t'(gx);
    s[4] = axis_t'(gy);
    s[5] = axis_t'(gz);
    return s;
  endfunction

  function automatic axis_t extreme_axis();
    case ($urandom_range(0, 4))
      0: return axis_t'(32767);
      1: return axis_t'(-32768);
      2: return axis_t'(0);
      3: return axis_t'(-1);
      default: return axis_t'(1);
    endcase
  endfunction

  // Gyro value with magnitude within three of the deadband, random past 32768.
  function automatic axis_t near_deadband_axis();
    int m;
    m = int'(deadband_model) + int'($urandom_range(0, 6)) - 3;
    if (m < 0) m = 0;
    if (m > 32768) m = $urandom_range(0, 32768);
    if ($urandom_range(0, 1) == 1) m = -m;
    if (m == 32768) m = -32768;
    return axis_t'(m);
  endfunction

  function automatic imu_vec_t random_sample();
    imu_vec_t s;
    int mode;
    int c;
    for (c = 0; c < FIRST_GYRO; c++)
      s[c] = ($urandom_range(0, 99) < 85) ? axis_t'($urandom) : extreme_axis();
    mode = $urandom_range(0, 99);
    for (c = FIRST_GYRO; c < NUM_CH; c++) begin
      if (mode < 45)
        s[c] = ($urandom_range(0, 5) == 0) ? axis_t'($urandom) : near_deadband_axis();
      else if (mode < 70)
        s[c] = axis_t'($urandom);
      else if (mode < 85)
        s[c] = axis_t'(int'($urandom_range(0, 127)) - 64);
      else
        s[c] = extreme_axis();
    end
    return s;
  endfunction

  // Send one sample; the prediction is made when the transfer happens.
  task automatic send_sample(input imu_vec_t s);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_accel_x = s[0];
    in_accel_y = s[1];
    in_accel_z = s[2];
    in_gyro_x = s[3];
    in_gyro_y = s[4];
    in_gyro_z = s[5];
    @(mon_cb);
    while (!mon_cb.in_ready) @(mon_cb);
    pending_averages.push_back(filter_sample(s));
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted average has come out.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
  endtask

  // Write the deadband register while the pipeline is empty.
  task automatic write_deadband(input logic [DBW-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data = value;
    @(mon_cb);
    while (!mon_cb.cfg_ready) @(mon_cb);
    deadband_model = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Full-scale samples and the deadband boundary at the reset value.
  task automatic test_extreme_samples();
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(32767, -32768, 0, -1, 1, 0));
    send_sample(make_sample(-1, 1, -32767, 499, -499, 0));
    send_sample(make_sample(100, -100, 7, 500, 0, 0));
    send_sample(make_sample(-7, 3, 0, 0, -500, 499));
    send_sample(make_sample(0, 0, 0, 499, 499, -500));
    send_sample(make_sample(12345, -12345, 1, -32768, 0, 0));
  endtask

  // Deadband at zero, just below, at and above the most negative magnitude, and at one.
  task automatic test_deadband_extremes();
    int n;
    write_deadband(16'd0);
    send_sample(make_sample(1, 2, 3, 0, 0, 0));
    send_sample(make_sample(-1, -2, -3, 1, -1, 0));
    write_deadband(16'd32768);
    send_sample(make_sample(4, 5, 6, -32768, 32767, -32767));
    send_sample(make_sample(-4, -5, -6, 32767, 32767, 32767));
    write_deadband(16'd32767);
    send_sample(make_sample(9, 9, 9, -32767, 32766, 0));
    send_sample(make_sample(-9, -9, -9, 32766, -32766, 0));
    write_deadband(16'hFFFF);
    send_sample(make_sample(0, 0, 0, -32768, -32768, -32768));
    write_deadband(16'd1);
    send_sample(make_sample(2, 2, 2, 0, 0, 0));
    send_sample(make_sample(-2, -2, -2, 0, 0, 1));
    // Fill every window with the most negative value.
    write_deadband(16'd0);
    for (n = 0; n < WIN_LEN; n++)
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
  endtask

  // Random samples in phases, each with its own deadband and pacing.
  task automatic test_random_stream();
    int phase;
    int sent;
    int reps;
    int k;
    imu_vec_t s;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_deadband(16'($urandom_range(0, 1200)));
        1: write_deadband(16'd0);
        2: write_deadband(16'd32768);
        3: write_deadband(16'hFFFF);
        4: write_deadband(16'($urandom_range(0, 65535)));
        5: write_deadband(idwa_pkg::DEADBAND_RESET);
        default: write_deadband(16'($urandom_range(1, 32767)));
      endcase
      src_idle_en = (phase % 3) != 2;
      sink_stall_en = (phase % 4) != 3;
      sent = 0;
      while (sent < RANDOM_ITEMS / NUM_PHASES) begin
        s = random_sample();
        // Now and then repeat one sample long enough to fill the windows.
        reps = ($urandom_range(0, 9) == 0) ? $urandom_range(WIN_LEN, WIN_LEN + 4) : 1;
        for (k = 0; k < reps; k++) send_sample(s);
        sent += reps;
      end
    end
    src_idle_en = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  // Result side back-pressure.
  initial begin : sink_pacing
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (sink_stall_en) hold = pick_gap();
      end
    end
  end

  // Compare each result transfer with the oldest predicted average.
  always @(mon_cb) begin : check_averages
    imu_vec_t got;
    imu_vec_t want;
    int c;
    if (mon_cb.rst_n && mon_cb.out_valid && mon_cb.out_ready) begin
      got = {mon_cb.out_avg_gyro_z, mon_cb.out_avg_gyro_y, mon_cb.out_avg_gyro_x,
             mon_cb.out_avg_accel_z, mon_cb.out_avg_accel_y, mon_cb.out_avg_accel_x};
      if (pending_averages.size() == 0) begin
        $error("result transfer with no average pending");
        fail_count++;
      end else begin
        want = pending_averages.pop_front();
        for (c = 0; c < NUM_CH; c++) begin
          if (got[c] !== want[c]) begin
            $error("%s: expected %0d, actual %0d", axis_name[c],
                   $signed(want[c]), $signed(got[c]));
            fail_count++;
          end
        end
      end
    end
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    int c;
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    in_gyro_x = '0;
    in_gyro_y = '0;
    in_gyro_z = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    src_idle_en = 1'b1;
    sink_stall_en = 1'b1;
    for (c = 0; c < NUM_CH; c++)
      for (i = 0; i < WIN_LEN; i++) window_mem[c][i] = '0;
    deadband_model = idwa_pkg::DEADBAND_RESET;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_extreme_samples();
    test_deadband_extremes();
    test_random_stream();

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/idwa_pkg.sv
sv/idwa_channel.sv
sv/imu_deadband_window_average_unit.sv
tb/imu_deadband_window_average_unit_test.sv
